// ----- hw/rtl/fvc_pkg.sv -----
`default_nettype none

package fvc_pkg;

  localparam int unsigned IdxW = 32;
  localparam int unsigned CntW = 32;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef struct packed {
    logic [IdxW-1:0] vertex_index;
    logic            list_start;
  } in_beat_t;

  typedef struct packed {
    logic            cache_hit;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] index_total;
  } out_beat_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic lookup;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fvc_cell.sv -----
`default_nettype none

// one cache entry: compares against the key and hands its entry to the next cell
module fvc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fvc_pkg::cell_ctrl_t         ctrl,
  input  wire logic [fvc_pkg::IdxW-1:0]    key,
  input  wire logic [fvc_pkg::IdxW-1:0]    prev_index,
  input  wire logic                        prev_valid,
  output logic      [fvc_pkg::IdxW-1:0]    index,
  output logic                             valid,
  output logic                             match
);

  logic [fvc_pkg::IdxW-1:0] index_r;
  logic                     valid_r;
  logic                     match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.lookup) begin
        match_r <= valid_r && (index_r == key);
      end
      if (ctrl.shift) begin
        valid_r <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      index_r <= prev_index;
    end
  end

  assign index = index_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fifo_vertex_cache_hit_counter_top.sv -----
// FIFO vertex cache hit counter
// in channel: one vertex index per beat, with list_start to clear the cache
//   and both counters before that index is looked up
// out channel: one beat per input beat, in order: hit flag, saturating hit
//   count and saturating index count for the current list
// the cache is a row of CACHE_ENTRIES cells; a miss shifts the new index into
//   the head cell and every cell hands its entry on, so the oldest falls off
//   the tail, which is first-in-first-out replacement
// steps per beat, in order: accept, compare in every cell, then reduce the
//   match bits and update the row and counters; a beat is only accepted
//   once the previous one has left the update step
// the next input beat is taken while a result waits in the output register;
//   if the receiver stalls, the following result holds in the update step
//   until the output register frees up, and no further beat is taken
// reset (rst_n low, synchronous): all entries empty, counters zero, both
//   channels idle
`default_nettype none

module fifo_vertex_cache_hit_counter_top #(
  parameter int unsigned CACHE_ENTRIES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fvc_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fvc_pkg::out_beat_t      out_data
);

  fvc_pkg::state_t state_r, state_nxt;

  // held input beat
  fvc_pkg::in_beat_t in_r;

  // counters
  logic [fvc_pkg::CntW-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [fvc_pkg::CntW-1:0] seen_cnt_r, seen_cnt_nxt;

  // output register
  logic               out_valid_r;
  fvc_pkg::out_beat_t out_r;

  // cell row wiring
  logic [fvc_pkg::IdxW-1:0] cell_index [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] cell_valid;
  logic [CACHE_ENTRIES-1:0] cell_match;
  logic [fvc_pkg::IdxW-1:0] chain_index [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] chain_valid;

  fvc_pkg::cell_ctrl_t ctrl;
  logic in_take;
  logic upd_go;
  logic hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fvc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = fvc_pkg::ST_LOOKUP;
      end
      fvc_pkg::ST_LOOKUP: begin
        state_nxt = fvc_pkg::ST_UPDATE;
      end
      fvc_pkg::ST_UPDATE: begin
        if (!out_valid_r || out_ready) state_nxt = fvc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fvc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    upd_go   = 1'b0;
    case (state_r)
      fvc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      fvc_pkg::ST_LOOKUP: begin
        in_ready = 1'b0;
      end
      fvc_pkg::ST_UPDATE: begin
        upd_go = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_take = in_valid && in_ready;

  // a list start empties the cache, so its lookup never counts as a hit
  assign hit = !in_r.list_start && (|cell_match);

  assign ctrl.lookup = (state_r == fvc_pkg::ST_LOOKUP);
  assign ctrl.shift  = upd_go && !hit;

  // head cell takes the new index; the rest take their neighbor's entry,
  // dropped to empty when the list restarts
  always_comb begin
    for (int i = 0; i < int'(CACHE_ENTRIES); i++) begin
      if (i == 0) begin
        chain_index[i] = in_r.vertex_index;
        chain_valid[i] = 1'b1;
      end else begin
        chain_index[i] = cell_index[i-1];
        chain_valid[i] = cell_valid[i-1] && !in_r.list_start;
      end
    end
  end

  for (genvar g = 0; g < int'(CACHE_ENTRIES); g++) begin : g_cell
    fvc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (in_r.vertex_index),
      .prev_index (chain_index[g]),
      .prev_valid (chain_valid[g]),
      .index      (cell_index[g]),
      .valid      (cell_valid[g]),
      .match      (cell_match[g])
    );
  end

  // saturating counters, restarted by list start
  always_comb begin
    hit_cnt_nxt  = in_r.list_start ? '0 : hit_cnt_r;
    seen_cnt_nxt = in_r.list_start ? '0 : seen_cnt_r;
    if (hit && hit_cnt_nxt != fvc_pkg::CntMax) begin
      hit_cnt_nxt = hit_cnt_nxt + 1'b1;
    end
    if (seen_cnt_nxt != fvc_pkg::CntMax) begin
      seen_cnt_nxt = seen_cnt_nxt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fvc_pkg::ST_IDLE;
      hit_cnt_r   <= '0;
      seen_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        hit_cnt_r   <= hit_cnt_nxt;
        seen_cnt_r  <= seen_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (upd_go) begin
      out_r.cache_hit   <= hit;
      out_r.hit_total   <= hit_cnt_nxt;
      out_r.index_total <= seen_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
